### hw/rtl/vaft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_pkg
// Sizes, fixed-point constants, arctangent table and shared types for the
// full-turn vector angle pipeline.
// ----------------------------------------------------------------------------
package vaft_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;

	// Products and their pre-scaled sum
	localparam int PROD_W    = 2 * COORD_WIDTH;
	localparam int PRE_SHIFT = (2 * COORD_WIDTH > 58) ? (2 * COORD_WIDTH - 58) : 0;
	localparam int SH_W      = PROD_W - PRE_SHIFT;
	localparam int SUM_W     = SH_W + 1;

	// CORDIC datapath
	localparam int XY_W      = 64;
	localparam int NORM_TOP  = 56;
	localparam int TURN_BITS = 40;
	localparam int RND_SHIFT = TURN_BITS - ANGLE_WIDTH;

	localparam logic [TURN_BITS-1:0] TURN_HALF = TURN_BITS'(1) << (TURN_BITS - 1);
	localparam logic [TURN_BITS:0]   RND_HALF  = (TURN_BITS + 1)'(1) << (RND_SHIFT - 1);

	// Stream widths, padded to whole bytes
	localparam int IN_DATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;

	// atan(2^-i) in units of 2^-40 turn
	localparam logic [TURN_BITS-1:0] ATAN_TURN [32] = '{
		40'd137438953472, 40'd81134951838, 40'd42869480287, 40'd21761217566,
		40'd10922836750,  40'd5466743129,  40'd2734038620,  40'd1367102738,
		40'd683561799,    40'd341782203,   40'd170891265,   40'd85445653,
		40'd42722829,     40'd21361415,    40'd10680707,    40'd5340354,
		40'd2670177,      40'd1335088,     40'd667544,      40'd333772,
		40'd166886,       40'd83443,       40'd41722,       40'd20861,
		40'd10430,        40'd5215,        40'd2608,        40'd1304,
		40'd652,          40'd326,         40'd163,         40'd81
	};

	// Quadrant of (dot, det) as {dot negative, det negative}
	typedef enum logic [1:0] {
		QUAD_I   = 2'b00,
		QUAD_IV  = 2'b01,
		QUAD_II  = 2'b10,
		QUAD_III = 2'b11
	} quad_t;

	typedef struct packed {
		quad_t quad;
		logic  degen;
	} meta_t;

endpackage
`default_nettype wire

### hw/rtl/vector_angle_full_turn.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angle_full_turn
// Angle from a first 2D vector to a second, as a fraction of one full turn.
// ----------------------------------------------------------------------------
// The block takes one vector pair per clock while s_tready is high and
// returns one angle per pair, in order. The pipeline has one stage of
// multipliers, one for the dot and cross sums, one for the magnitudes, two
// for the normalizing shift, one per CORDIC iteration, one for the quadrant
// fold and the output register. Every stage is one add or one multiply
// deep, so a new pair enters whenever s_tready is high. A two-entry output
// (output register plus skid register) lets the pipeline keep accepting
// while a result waits; s_tready drops only when both entries are full.
// When dot and cross product are both zero the angle reads 0 and tuser is 1.
// ----------------------------------------------------------------------------
module vector_angle_full_turn import vaft_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// first_x, first_y, second_x, second_y (lowest bits first)
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// turn_angle, zero padded
	output      logic [OUT_DATA_W-1:0] m_tdata,
	// degenerate
	output      logic                  m_tuser
);

	logic en;

	// ------------------------------------------------------------------
	// Stage 1: products
	// ------------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
	logic signed [PROD_W-1:0] axbx_s1, ayby_s1, axby_s1, aybx_s1;
	logic vld_s1;

	assign ax = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
	assign ay = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
	assign bx = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
	assign by = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];

	always_ff @(posedge clk) begin
		if (en) begin
			axbx_s1 <= ax * bx;
			ayby_s1 <= ay * by;
			axby_s1 <= ax * by;
			aybx_s1 <= ay * bx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: dot and cross sums (products floor-shifted by PRE_SHIFT)
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0] dot_s2, det_s2;
	logic signed [SUM_W-1:0] axbx_e, ayby_e, axby_e, aybx_e;
	logic vld_s2;

	assign axbx_e = {axbx_s1[PROD_W-1], axbx_s1[PROD_W-1 -: SH_W]};
	assign ayby_e = {ayby_s1[PROD_W-1], ayby_s1[PROD_W-1 -: SH_W]};
	assign axby_e = {axby_s1[PROD_W-1], axby_s1[PROD_W-1 -: SH_W]};
	assign aybx_e = {aybx_s1[PROD_W-1], aybx_s1[PROD_W-1 -: SH_W]};

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= axbx_e + ayby_e;
			det_s2 <= axby_e - aybx_e;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: magnitudes, quadrant and degenerate flag
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] dot_mag, det_mag;
	logic [XY_W-1:0] mx_s3, my_s3;
	meta_t meta_s3;
	logic vld_s3;

	assign dot_mag = dot_s2[SUM_W-1] ? (~dot_s2 + SUM_W'(1)) : dot_s2;
	assign det_mag = det_s2[SUM_W-1] ? (~det_s2 + SUM_W'(1)) : det_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3         <= XY_W'(dot_mag);
			my_s3         <= XY_W'(det_mag);
			meta_s3.quad  <= quad_t'({dot_s2[SUM_W-1], det_s2[SUM_W-1]});
			meta_s3.degen <= (dot_s2 == '0) && (det_s2 == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 and 5: shift both magnitudes up until the larger one
	// reaches 2^55 (binary steps of 32, 16, 8 then 4, 2, 1)
	// ------------------------------------------------------------------
	logic [XY_W-1:0] n4_m, n4_x, n4_y;
	logic [XY_W-1:0] nm_s4, nx_s4, ny_s4;
	logic [XY_W-1:0] n5_m, n5_x, n5_y;
	meta_t meta_s4;
	logic vld_s4;

	always_comb begin
		n4_m = (mx_s3 > my_s3) ? mx_s3 : my_s3;
		n4_x = mx_s3;
		n4_y = my_s3;
		for (int j = 0; j < 3; j++) begin
			if ((n4_m >> (NORM_TOP - (32 >> j))) == '0) begin
				n4_m = n4_m << (32 >> j);
				n4_x = n4_x << (32 >> j);
				n4_y = n4_y << (32 >> j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s4   <= n4_m;
			nx_s4   <= n4_x;
			ny_s4   <= n4_y;
			meta_s4 <= meta_s3;
		end
	end

	always_comb begin
		n5_m = nm_s4;
		n5_x = nx_s4;
		n5_y = ny_s4;
		for (int j = 3; j < 6; j++) begin
			if ((n5_m >> (NORM_TOP - (32 >> j))) == '0) begin
				n5_m = n5_m << (32 >> j);
				n5_x = n5_x << (32 >> j);
				n5_y = n5_y << (32 >> j);
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring, one iteration per stage; entry 0 is stage 5
	// ------------------------------------------------------------------
	logic signed [XY_W-1:0]  cx_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0]  cy_s [CORDIC_STEPS+1];
	logic [TURN_BITS-1:0]    cz_s [CORDIC_STEPS+1];
	meta_t                   cmeta_s [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0]   cvld_s;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]    <= n5_x;
			cy_s[0]    <= n5_y;
			cz_s[0]    <= '0;
			cmeta_s[0] <= meta_s4;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][XY_W-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ATAN_TURN[i];
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ATAN_TURN[i];
				end
				cmeta_s[i+1] <= cmeta_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Fold stage: map the first-quadrant angle to the full turn
	// ------------------------------------------------------------------
	logic [TURN_BITS-1:0] fold_a;
	logic [TURN_BITS-1:0] fold_turn_s;
	logic                 fold_degen_s;
	logic                 fold_vld_s;

	always_comb begin
		unique case (cmeta_s[CORDIC_STEPS].quad)
			QUAD_I:   fold_a = cz_s[CORDIC_STEPS];
			QUAD_II:  fold_a = TURN_HALF - cz_s[CORDIC_STEPS];
			QUAD_III: fold_a = TURN_HALF + cz_s[CORDIC_STEPS];
			QUAD_IV:  fold_a = '0 - cz_s[CORDIC_STEPS];
			default:  fold_a = cz_s[CORDIC_STEPS];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_turn_s  <= fold_a;
			fold_degen_s <= cmeta_s[CORDIC_STEPS].degen;
		end
	end

	// Round to the output width; the carry out of the top bit wraps to 0
	logic [TURN_BITS:0]     rnd_sum;
	logic [ANGLE_WIDTH-1:0] angle_d;

	assign rnd_sum = {1'b0, fold_turn_s} + RND_HALF;
	assign angle_d = fold_degen_s ? '0 : rnd_sum[TURN_BITS-1:RND_SHIFT];

	// ------------------------------------------------------------------
	// Valid bits
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			cvld_s     <= '0;
			fold_vld_s <= 1'b0;
		end else if (en) begin
			vld_s1     <= s_tvalid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			cvld_s     <= {cvld_s[CORDIC_STEPS-1:0], vld_s4};
			fold_vld_s <= cvld_s[CORDIC_STEPS];
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid register
	// ------------------------------------------------------------------
	logic [ANGLE_WIDTH-1:0] angle_q, skid_angle_q;
	logic                   degen_q, skid_degen_q;
	logic                   out_vld_q, skid_vld_q;
	logic                   out_free;

	assign en       = !skid_vld_q;
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_free) begin
				out_vld_q <= fold_vld_s;
			end else if (fold_vld_s) begin
				skid_vld_q <= 1'b1;
			end
		end else if (m_tready) begin
			// drain the skid entry into the output register
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_free) begin
				angle_q <= angle_d;
				degen_q <= fold_degen_s;
			end else begin
				skid_angle_q <= angle_d;
				skid_degen_q <= fold_degen_s;
			end
		end else if (m_tready) begin
			angle_q <= skid_angle_q;
			degen_q <= skid_degen_q;
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(angle_q);
	assign m_tuser  = degen_q;

`ifndef SYNTHESIS
	// The skid entry only fills behind a waiting output transaction
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	// Taking the output while the skid is full refills the output
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && m_tready) |=> (out_vld_q && !skid_vld_q))
		else $error("skid entry not moved to output");

	// A degenerate pair always reads angle zero
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && degen_q) |-> (angle_q == '0))
		else $error("degenerate result with nonzero angle");
`endif

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: full-turn vector angle stream check
// Sends vector pairs over the input stream and checks every angle that comes
// back against a behavioral copy of the fixed-point arithmetic: dot and cross
// product, CORDIC vectoring, quadrant fold and rounding to the output width.
// A directed set of corner pairs comes first, then random pairs. Both stream
// sides idle at random, and the receiver holds off long enough to back the
// pipeline up into the input.
// ----------------------------------------------------------------------------
module tb;
	import vaft_pkg::*;

	localparam int RANDOM_PAIRS = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = CORDIC_STEPS + 16;
	localparam int LONG_HOLD    = 600;

	// first field in the lowest bits
	typedef struct packed {
		logic [COORD_WIDTH-1:0] second_y;
		logic [COORD_WIDTH-1:0] second_x;
		logic [COORD_WIDTH-1:0] first_y;
		logic [COORD_WIDTH-1:0] first_x;
	} vec_pair_t;

	typedef struct {
		vec_pair_t              pair;
		logic [ANGLE_WIDTH-1:0] angle;
		logic                   degenerate;
	} angle_result_t;

	class angle_scoreboard;
		angle_result_t pending_angles[$];
		int            mismatches = 0;

		function automatic angle_result_t predict_turn_angle(vec_pair_t p);
			angle_result_t res;
			longint        ax, ay, bx, by, dot, det, x, y, z, m, xs, ys;
			logic [63:0]   full_turn, half_turn, a0, r;
			quad_t         quad;
			ax = longint'($signed(p.first_x));
			ay = longint'($signed(p.first_y));
			bx = longint'($signed(p.second_x));
			by = longint'($signed(p.second_y));
			dot = ((ax * bx) >>> PRE_SHIFT) + ((ay * by) >>> PRE_SHIFT);
			det = ((ax * by) >>> PRE_SHIFT) - ((ay * bx) >>> PRE_SHIFT);
			res.pair = p;
			res.angle = '0;
			res.degenerate = 1'b1;
			if (dot == 0 && det == 0)
				return res;
			res.degenerate = 1'b0;
			x = dot < 0 ? -dot : dot;
			y = det < 0 ? -det : det;
			m = x > y ? x : y;
			// normalize so the larger magnitude reaches 2^55
			while (m < (64'sd1 <<< 55)) begin
				m = m <<< 1;
				x = x <<< 1;
				y = y <<< 1;
			end
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> (i & 31);
				ys = y >>> (i & 31);
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(ATAN_TURN[i & 31]);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(ATAN_TURN[i & 31]);
				end
			end
			full_turn = 64'd1 << TURN_BITS;
			half_turn = full_turn >> 1;
			a0 = z;
			quad = quad_t'({dot < 0, det < 0});
			case (quad)
				QUAD_I:   r = a0;
				QUAD_II:  r = half_turn - a0;
				QUAD_III: r = half_turn + a0;
				default:  r = full_turn - a0;
			endcase
			r = r & (full_turn - 64'd1);
			r = (r + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
			res.angle = r[ANGLE_WIDTH-1:0];
			return res;
		endfunction

		function void note_pair(vec_pair_t p);
			pending_angles.push_back(predict_turn_angle(p));
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic degen);
			angle_result_t want;
			if (pending_angles.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: angle %0d degenerate %0b", data, degen);
				mismatches++;
				return;
			end
			want = pending_angles.pop_front();
			if (data !== OUT_DATA_W'(want.angle) || degen !== want.degenerate) begin
				if (mismatches < 10)
					$display("mismatch for (%0d,%0d)->(%0d,%0d): expected %0d/%0b, got %0d/%0b",
						$signed(want.pair.first_x), $signed(want.pair.first_y),
						$signed(want.pair.second_x), $signed(want.pair.second_y),
						want.angle, want.degenerate, data, degen);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// first_x, first_y, second_x, second_y
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// turn_angle
	logic [OUT_DATA_W-1:0] m_tdata;
	// degenerate
	logic                  m_tuser;

	angle_scoreboard board = new;
	int              cycles = 0;

	vector_angle_full_turn DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic vec_pair_t make_pair(int ax, int ay, int bx, int by);
		vec_pair_t p;
		p.first_x  = ax[COORD_WIDTH-1:0];
		p.first_y  = ay[COORD_WIDTH-1:0];
		p.second_x = bx[COORD_WIDTH-1:0];
		p.second_y = by[COORD_WIDTH-1:0];
		return p;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0:       return -32768;
			1:       return -1;
			2:       return 0;
			3:       return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic vec_pair_t random_pair();
		int ax, ay, d;
		ax = $signed($urandom_range(0, 65535)) - 32768;
		ay = $signed($urandom_range(0, 65535)) - 32768;
		case ($urandom_range(0, 9))
			5, 6:
				return make_pair($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
			7:
				return make_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
			8:
				// same or opposite direction
				return $urandom_range(0, 1) ? make_pair(ax, ay, ax, ay) : make_pair(ax, ay, -ax, -ay);
			9: begin
				// small turn either way, lands near zero or just under a full turn
				d = $urandom_range(0, 6) - 3;
				return make_pair(ax, ay, ax + d, ay - d);
			end
			default:
				return vec_pair_t'({$urandom(), $urandom()});
		endcase
	endfunction

	// hold valid across back-to-back transactions, drop it only for a gap
	task automatic send_pair(vec_pair_t p, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		board.note_pair(p);
	endtask

	initial begin : source
		vec_pair_t corner_pairs[$];
		bit        steady;
		int        gap;
		corner_pairs = '{
			make_pair(0, 0, 0, 0),
			make_pair(0, 0, 123, -45),
			make_pair(-32768, -32768, 0, 0),
			make_pair(1, 0, 1, 0),
			make_pair(1, 0, 0, 1),
			make_pair(1, 0, -1, 0),
			make_pair(1, 0, 0, -1),
			make_pair(-32768, -32768, -32768, -32768),
			make_pair(-32768, -32768, 32767, 32767),
			make_pair(32767, -32768, -32768, 32767),
			make_pair(-32768, 32767, 32767, -32768),
			make_pair(1, 0, 32767, -1),
			make_pair(32767, 0, 32767, 1),
			make_pair(3, 4, -4, 3),
			make_pair(-1, -1, 1, -1),
			make_pair(5, -7, -3, -2),
			make_pair(2, 1, -1, -3),
			make_pair(0, -32768, -32768, 0),
			make_pair(32767, 32767, -1, -1),
			make_pair(-1, 0, 0, 1)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_pairs[i])
			send_pair(corner_pairs[i], $urandom_range(0, 18));
		steady = 1'b0;
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n % 50 == 0)
				steady = ($urandom_range(0, 3) == 0);
			gap = steady ? 0 : $urandom_range(0, 18);
			send_pair(random_pair(), gap);
		end
		s_tvalid <= 1'b0;
		while (board.pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : sink
		int taken;
		int stall;
		bit steady;
		taken = 0;
		steady = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			stall = steady ? 0 : $urandom_range(0, 18);
			// back the pipeline up into the input
			if (taken == 150 || taken == 450)
				stall = LONG_HOLD;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata, m_tuser);
			taken++;
		end
	end

endmodule
`default_nettype wire
